// ===== rtl/cdo_pkg.sv =====
// Shared types, constants and calendar helper functions for the date offset block.
package cdo_pkg;

  localparam int COUNT_BITS = 16;
  localparam int YEAR_W     = 14;
  localparam int MONTH_W    = 4;
  localparam int DAY_W      = 5;
  localparam int WDAY_W     = 3;
  localparam int STATUS_W   = 2;

  localparam int YEAR_MAX   = 9999;
  localparam int YEAR_CYCLE = 400;
  localparam int WEEK_DAYS  = 7;

  // forward walks may run past the 14-bit year range before the range check
  localparam int WORK_YEAR_W = $clog2((1 << YEAR_W) + (1 << COUNT_BITS) / 365 + 2);

  // restoring reduction: count mod 7 and year mod 400 share one step counter
  localparam int YEAR_STEP_TOP = 5;
  localparam int RED_TOP = (COUNT_BITS - 3 > YEAR_STEP_TOP) ? COUNT_BITS - 3 : YEAR_STEP_TOP;
  localparam int RED_W   = $clog2(RED_TOP + 1);

  localparam logic OP_FWD = 1'b0;
  localparam logic OP_BWD = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_BAD_DAY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_RANGE   = 2'd2;

  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  localparam logic [DAY_W-1:0] MONTH_LEN [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  typedef struct packed {
    logic                  operation;
    logic [COUNT_BITS-1:0] day_count;
    logic [YEAR_W-1:0]     in_year;
    logic [MONTH_W-1:0]    in_month;
    logic [DAY_W-1:0]      in_day;
    logic [WDAY_W-1:0]     in_weekday;
  } in_word_t;

  typedef struct packed {
    logic [YEAR_W-1:0]   out_year;
    logic [MONTH_W-1:0]  out_month;
    logic [DAY_W-1:0]    out_day;
    logic [WDAY_W-1:0]   out_weekday;
    logic [STATUS_W-1:0] status;
  } out_word_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_REDUCE,
    S_CHECK,
    S_WALK,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic reduce;
    logic check;
    logic walk;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic reduce_last;
    logic bad_day;
    logic walk_done;
    logic out_free;
  } dp_sts_t;

  // rem is the year modulo 400
  function automatic logic is_leap(input logic [YEAR_W-1:0] rem);
    logic leap;
    begin
      leap = (rem[1:0] == 2'b00) && (rem != YEAR_W'(100)) && (rem != YEAR_W'(200)) &&
             (rem != YEAR_W'(300));
      return leap;
    end
  endfunction

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] month,
                                                  input logic leap);
    logic [DAY_W-1:0] len;
    begin
      len = '0;
      if (month >= MONTH_JAN && month <= MONTH_DEC) begin
        len = MONTH_LEN[month - MONTH_JAN];
        if (month == MONTH_FEB && leap) begin
          len = len + DAY_W'(1);
        end
      end
      return len;
    end
  endfunction

endpackage

// ===== rtl/cdo_ctrl.sv =====
// Controller state machine sequencing reduce, check, month walk and result write.
module cdo_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  cdo_pkg::dp_sts_t sts,
  output cdo_pkg::dp_cmd_t cmd
);
  import cdo_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = rst || (state != S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (in_valid && !rst) begin
          cmd.load   = 1'b1;
          state_next = S_REDUCE;
        end
      end
      S_REDUCE: begin
        cmd.reduce = 1'b1;
        if (sts.reduce_last) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.check  = 1'b1;
        state_next = sts.bad_day ? S_FINISH : S_WALK;
      end
      S_WALK: begin
        cmd.walk = 1'b1;
        if (sts.walk_done) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/cdo_dpath.sv =====
// Datapath: mod-7 and mod-400 reduction, month-by-month walk and output register.
module cdo_dpath (
  input  logic              clk,
  input  logic              rst,
  input  cdo_pkg::in_word_t in_data,
  input  cdo_pkg::dp_cmd_t  cmd,
  output cdo_pkg::dp_sts_t  sts,
  input  logic              out_stall,
  output logic              out_valid,
  output cdo_pkg::out_word_t out_data
);
  import cdo_pkg::*;

  in_word_t               in_reg;
  logic [WORK_YEAR_W-1:0] year;
  logic [MONTH_W-1:0]     month;
  logic [DAY_W-1:0]       day;
  logic [COUNT_BITS-1:0]  sub;
  logic [COUNT_BITS-1:0]  crem;
  logic [YEAR_W-1:0]      yrem;
  logic [RED_W-1:0]       k;
  logic                   bad_day;
  logic                   range_err;

  logic                  leap;
  logic [DAY_W-1:0]      ml;
  logic [COUNT_BITS:0]   fwd_sum;
  logic                  fwd_fit;
  logic                  bwd_fit;
  logic                  bwd_floor;
  logic [COUNT_BITS-1:0] seven_sh;
  logic [YEAR_W-1:0]     yr_sh;
  logic [WDAY_W:0]       wf_sum;
  logic [WDAY_W+1:0]     wb_sum;
  logic [WDAY_W-1:0]     wday;
  logic [STATUS_W-1:0]   status;

  assign leap      = is_leap(yrem);
  assign ml        = month_len(month, leap);
  assign fwd_sum   = {1'b0, sub} + (COUNT_BITS+1)'(day);
  assign fwd_fit   = fwd_sum <= (COUNT_BITS+1)'(ml);
  assign bwd_fit   = COUNT_BITS'(day) > sub;
  assign bwd_floor = (month == MONTH_JAN) && (year == '0);
  assign seven_sh  = COUNT_BITS'(WEEK_DAYS) << k;
  assign yr_sh     = YEAR_W'(YEAR_CYCLE) << k;

  assign sts.reduce_last = (k == '0);
  assign sts.bad_day     = (day == '0) || (day > ml);
  assign sts.walk_done   = (sub == '0) ||
                           ((in_reg.operation == OP_FWD) ? fwd_fit : (bwd_fit || bwd_floor));
  assign sts.out_free    = !out_valid || !out_stall;

  // weekday shift, crem holds count mod 7 after the reduction
  always_comb begin
    wf_sum = {1'b0, in_reg.in_weekday} + {1'b0, crem[WDAY_W-1:0]};
    wb_sum = (WDAY_W+2)'(in_reg.in_weekday) + (WDAY_W+2)'(WEEK_DAYS) -
             (WDAY_W+2)'(crem[WDAY_W-1:0]);
    if (in_reg.operation == OP_FWD) begin
      wday = (wf_sum >= (WDAY_W+1)'(WEEK_DAYS)) ?
             WDAY_W'(wf_sum - (WDAY_W+1)'(WEEK_DAYS)) : WDAY_W'(wf_sum);
    end else begin
      priority if (wb_sum >= (WDAY_W+2)'(2 * WEEK_DAYS)) begin
        wday = WDAY_W'(wb_sum - (WDAY_W+2)'(2 * WEEK_DAYS));
      end else if (wb_sum >= (WDAY_W+2)'(WEEK_DAYS)) begin
        wday = WDAY_W'(wb_sum - (WDAY_W+2)'(WEEK_DAYS));
      end else begin
        wday = WDAY_W'(wb_sum);
      end
    end
    priority if (bad_day) begin
      status = STATUS_BAD_DAY;
    end else if (range_err || (year > WORK_YEAR_W'(YEAR_MAX))) begin
      status = STATUS_RANGE;
    end else begin
      status = STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_reg    <= in_data;
      year      <= WORK_YEAR_W'(in_data.in_year);
      month     <= in_data.in_month;
      day       <= in_data.in_day;
      sub       <= in_data.day_count;
      crem      <= in_data.day_count;
      yrem      <= in_data.in_year;
      k         <= RED_W'(RED_TOP);
      bad_day   <= 1'b0;
      range_err <= 1'b0;
    end
    if (cmd.reduce) begin
      k <= k - RED_W'(1);
      if (crem >= seven_sh) begin
        crem <= crem - seven_sh;
      end
      if ((k <= RED_W'(YEAR_STEP_TOP)) && (yrem >= yr_sh)) begin
        yrem <= yrem - yr_sh;
      end
    end
    if (cmd.check) begin
      bad_day <= sts.bad_day;
    end
    if (cmd.walk && (sub != '0)) begin
      if (in_reg.operation == OP_FWD) begin
        if (fwd_fit) begin
          day <= fwd_sum[DAY_W-1:0];
        end else begin
          sub <= sub - COUNT_BITS'(ml - day + DAY_W'(1));
          day <= DAY_W'(1);
          if (month == MONTH_DEC) begin
            month <= MONTH_JAN;
            year  <= year + WORK_YEAR_W'(1);
            yrem  <= (yrem == YEAR_W'(YEAR_CYCLE - 1)) ? '0 : yrem + YEAR_W'(1);
          end else begin
            month <= month + MONTH_W'(1);
          end
        end
      end else begin
        priority if (bwd_fit) begin
          day <= day - sub[DAY_W-1:0];
        end else if (bwd_floor) begin
          range_err <= 1'b1;
        end else begin
          sub <= sub - COUNT_BITS'(day);
          if (month == MONTH_JAN) begin
            month <= MONTH_DEC;
            year  <= year - WORK_YEAR_W'(1);
            yrem  <= (yrem == '0) ? YEAR_W'(YEAR_CYCLE - 1) : yrem - YEAR_W'(1);
            day   <= month_len(MONTH_DEC, 1'b0);
          end else begin
            month <= month - MONTH_W'(1);
            day   <= month_len(month - MONTH_W'(1), leap);
          end
        end
      end
    end
    if (cmd.finish) begin
      out_data.status <= status;
      if (status != STATUS_OK) begin
        out_data.out_year    <= in_reg.in_year;
        out_data.out_month   <= in_reg.in_month;
        out_data.out_day     <= in_reg.in_day;
        out_data.out_weekday <= in_reg.in_weekday;
      end else begin
        out_data.out_year    <= year[YEAR_W-1:0];
        out_data.out_month   <= month;
        out_data.out_day     <= day;
        out_data.out_weekday <= wday;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// ===== rtl/calendar_date_day_offset_top.sv =====
// Steps: mod-7 and mod-400 reduction (S_REDUCE), the day check (S_CHECK), the month walk
// (S_WALK, skipped for a bad day) and the result write (S_FINISH) once the output is free.
// One word at a time: no new word is taken before the result write, but a new word is taken
// while the previous result still sits in the output register.
// Reset: synchronous; clears the controller state and the output valid, no data.
// Top level of the Gregorian date offset block.
module calendar_date_day_offset_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  cdo_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output cdo_pkg::out_word_t out_data
);
  import cdo_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  cdo_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  cdo_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// ===== rtl/cdo_check.sv =====
// Port-level assertion checker for the date offset block, bound to the top level.
module cdo_check (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input cdo_pkg::out_word_t out_data
);
  import cdo_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.status == STATUS_OK) || (out_data.status == STATUS_BAD_DAY) ||
                  (out_data.status == STATUS_RANGE))
    else $error("undefined status code");

  a_ok_date: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.status == STATUS_OK) |->
      (out_data.out_weekday < WDAY_W'(WEEK_DAYS)) &&
      (out_data.out_year <= YEAR_W'(YEAR_MAX)) && (out_data.out_day != '0) &&
      (out_data.out_month >= MONTH_JAN) && (out_data.out_month <= MONTH_DEC))
    else $error("ok status with malformed date");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second word accepted while busy");

  // idle block has no result pending behind the one taken
  a_single_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !in_stall |=> !out_valid)
    else $error("result word repeated after being taken");

endmodule

bind calendar_date_day_offset_top cdo_check u_cdo_check (.*);
